FILE: hw/rtl/sveq_pkg.sv
// ----------------------------------------------------------------------------
// State-variable EQ section package
// Fixed-point formats, microcode control word, configuration record and the
// saturation helpers shared by the section's modules.
// ----------------------------------------------------------------------------
package sveq_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 24;
  localparam int GAIN_W     = 31;
  localparam int STATE_W    = 48;
  localparam int STATE_FRAC = STATE_W - SAMPLE_W;

  localparam int MUL_B_W = ((COEF_FRAC > STATE_W - COEF_FRAC) ? COEF_FRAC
                                                              : STATE_W - COEF_FRAC) + 1;
  localparam int PROD_W  = COEF_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 3;

  localparam int N_REGS     = 7;
  localparam int REG_IDX_W  = $clog2(N_REGS);
  localparam int APB_ADDR_W = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_COEF_A0  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_COEF_A1  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_COEF_A2  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_MIX_M0   = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_MIX_M1   = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_MIX_M2   = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_OUT_GAIN = REG_IDX_W'(6);

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << COEF_FRAC;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_WAIT_OUT
  } seq_op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_A0,
    C_A1,
    C_A2,
    C_M0,
    C_M1,
    C_M2,
    C_GAIN
  } coef_sel_t;

  typedef enum logic [2:0] {
    V_S0,
    V_V2,
    V_X,
    V_V0,
    V_V1,
    V_Y
  } val_sel_t;

  typedef enum logic {
    HALF_LO,
    HALF_HI
  } half_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD,
    ACC_SET,
    ACC_S1_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_LOAD,
    WB_V2,
    WB_V0,
    WB_V1,
    WB_STATE,
    WB_Y,
    WB_OUT
  } wb_t;

  typedef struct packed {
    seq_op_t   seq;
    coef_sel_t coef;
    val_sel_t  val;
    half_t     half;
    acc_op_t   acc;
    wb_t       wb;
  } ctl_t;

  typedef struct packed {
    logic [COEF_W-1:0] a0;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] m0;
    logic [COEF_W-1:0] m1;
    logic [COEF_W-1:0] m2;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic               clip;
    logic [STATE_W-1:0] val;
  } sat_state_t;

  typedef struct packed {
    logic                clip;
    logic [SAMPLE_W-1:0] val;
  } sat_sample_t;

  function automatic sat_state_t sat_state(input logic signed [ACC_W-1:0] a);
    sat_state_t            r;
    logic [ACC_W-STATE_W:0] hi_bits;
    hi_bits = a[ACC_W-1:STATE_W-1];
    r.clip  = !((&hi_bits) || !(|hi_bits));
    r.val   = r.clip ? {a[ACC_W-1], {(STATE_W-1){~a[ACC_W-1]}}} : a[STATE_W-1:0];
    return r;
  endfunction

  function automatic sat_sample_t sat_sample(input logic signed [ACC_W-1:0] a);
    sat_sample_t                               r;
    logic [ACC_W-STATE_FRAC-SAMPLE_W:0] hi_bits;
    hi_bits = a[ACC_W-1:STATE_FRAC+SAMPLE_W-1];
    r.clip  = !((&hi_bits) || !(|hi_bits));
    r.val   = r.clip ? {a[ACC_W-1], {(SAMPLE_W-1){~a[ACC_W-1]}}}
                     : a[STATE_FRAC+SAMPLE_W-1:STATE_FRAC];
    return r;
  endfunction

endpackage

FILE: hw/rtl/sveq_if.sv
// ----------------------------------------------------------------------------
// State-variable EQ section channels
// Valid/ready channels for the input samples and the filtered results.
// ----------------------------------------------------------------------------
interface sveq_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sveq_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface sveq_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sveq_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: hw/rtl/state_variable_eq_section.sv
// ----------------------------------------------------------------------------
// State-variable EQ section
// One trapezoidal state-variable filter section with output mix, gain and
// saturation, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// A sample beat is accepted on the first step of a 21-step microprogram and
// its result is loaded into the output register on the last step, so a new
// sample beat waits until the program has run through. The program runs
// all sixteen half-width products of the section through one shared 32x25
// multiplier, one product per cycle, each accumulated in the next step.
// A new sample beat is accepted while the previous result still waits in the
// output register; if that result has not been taken when the next one is
// ready, the program holds on its last step until the output register frees
// up. Configuration writes are meant for idle periods; the integrator states
// reset to zero and are only cleared again by reset.
module state_variable_eq_section (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sveq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sveq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sveq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  sveq_sample_if.sink                         samples,
  sveq_result_if.source                       results
);

  sveq_pkg::cfg_t cfg;
  sveq_pkg::ctl_t ctl;
  logic           out_free;

  assign out_free = !results.valid || results.ready;

  sveq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sveq_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .out_free (out_free),
    .in_ready (samples.ready),
    .ctl      (ctl)
  );

  sveq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .sample_in (samples.sample_in),
    .results   (results)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("sample accepted while the program was still running");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.wb == sveq_pkg::WB_OUT) |-> out_free)
    else $error("result loaded over an untaken result");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(ctl.wb == sveq_pkg::WB_OUT))
    else $error("result valid raised without a result load");

endmodule

FILE: hw/rtl/sveq_regs.sv
// ----------------------------------------------------------------------------
// State-variable EQ section register file
// APB-style configuration registers for the coefficients, mix and gain.
// ----------------------------------------------------------------------------
module sveq_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sveq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sveq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sveq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output sveq_pkg::cfg_t                      cfg
);

  logic [sveq_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[sveq_pkg::APB_ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a0   <= sveq_pkg::COEF_ONE;
      cfg.a1   <= '0;
      cfg.a2   <= '0;
      cfg.m0   <= sveq_pkg::COEF_ONE;
      cfg.m1   <= '0;
      cfg.m2   <= '0;
      cfg.gain <= sveq_pkg::GAIN_ONE;
    end else if (wr) begin
      unique case (idx)
        sveq_pkg::REG_COEF_A0:  cfg.a0   <= pwdata[sveq_pkg::COEF_W-1:0];
        sveq_pkg::REG_COEF_A1:  cfg.a1   <= pwdata[sveq_pkg::COEF_W-1:0];
        sveq_pkg::REG_COEF_A2:  cfg.a2   <= pwdata[sveq_pkg::COEF_W-1:0];
        sveq_pkg::REG_MIX_M0:   cfg.m0   <= pwdata[sveq_pkg::COEF_W-1:0];
        sveq_pkg::REG_MIX_M1:   cfg.m1   <= pwdata[sveq_pkg::COEF_W-1:0];
        sveq_pkg::REG_MIX_M2:   cfg.m2   <= pwdata[sveq_pkg::COEF_W-1:0];
        sveq_pkg::REG_OUT_GAIN: cfg.gain <= pwdata[sveq_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sveq_pkg::REG_COEF_A0:  prdata = sveq_pkg::APB_DATA_W'(cfg.a0);
      sveq_pkg::REG_COEF_A1:  prdata = sveq_pkg::APB_DATA_W'(cfg.a1);
      sveq_pkg::REG_COEF_A2:  prdata = sveq_pkg::APB_DATA_W'(cfg.a2);
      sveq_pkg::REG_MIX_M0:   prdata = sveq_pkg::APB_DATA_W'(cfg.m0);
      sveq_pkg::REG_MIX_M1:   prdata = sveq_pkg::APB_DATA_W'(cfg.m1);
      sveq_pkg::REG_MIX_M2:   prdata = sveq_pkg::APB_DATA_W'(cfg.m2);
      sveq_pkg::REG_OUT_GAIN: prdata = sveq_pkg::APB_DATA_W'(cfg.gain);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/sveq_sequencer.sv
// ----------------------------------------------------------------------------
// State-variable EQ section sequencer
// Step counter and microcode ROM that drive the shared multiply datapath.
// ----------------------------------------------------------------------------
module sveq_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_free,
  output logic           in_ready,
  output sveq_pkg::ctl_t ctl
);

  localparam int N_STEPS = 21;
  localparam int STEP_W  = $clog2(N_STEPS);

  // Fields: sequencing, coefficient, value, value half, accumulator, write-back.
  // A product issued in one step reaches the accumulator in the next step.
  localparam sveq_pkg::ctl_t ROM [N_STEPS] = '{
    '{sveq_pkg::SEQ_WAIT_IN, sveq_pkg::C_NONE, sveq_pkg::V_S0, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_HOLD, sveq_pkg::WB_LOAD},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_A0, sveq_pkg::V_S0, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_CLR, sveq_pkg::WB_V2},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_A0, sveq_pkg::V_S0, sveq_pkg::HALF_HI,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_A1, sveq_pkg::V_V2, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_A1, sveq_pkg::V_V2, sveq_pkg::HALF_HI,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_A1, sveq_pkg::V_S0, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_A1, sveq_pkg::V_S0, sveq_pkg::HALF_HI,
      sveq_pkg::ACC_S1_ADD, sveq_pkg::WB_V0},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_A2, sveq_pkg::V_V2, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_A2, sveq_pkg::V_V2, sveq_pkg::HALF_HI,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_M0, sveq_pkg::V_X, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_M0, sveq_pkg::V_X, sveq_pkg::HALF_HI,
      sveq_pkg::ACC_SET, sveq_pkg::WB_V1},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_M1, sveq_pkg::V_V0, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_STATE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_M1, sveq_pkg::V_V0, sveq_pkg::HALF_HI,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_M2, sveq_pkg::V_V1, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_M2, sveq_pkg::V_V1, sveq_pkg::HALF_HI,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_NONE, sveq_pkg::V_S0, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_NONE, sveq_pkg::V_S0, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_CLR, sveq_pkg::WB_Y},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_GAIN, sveq_pkg::V_Y, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_HOLD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_GAIN, sveq_pkg::V_Y, sveq_pkg::HALF_HI,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_NEXT, sveq_pkg::C_NONE, sveq_pkg::V_S0, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_ADD, sveq_pkg::WB_NONE},
    '{sveq_pkg::SEQ_WAIT_OUT, sveq_pkg::C_NONE, sveq_pkg::V_S0, sveq_pkg::HALF_LO,
      sveq_pkg::ACC_HOLD, sveq_pkg::WB_OUT}
  };

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  sveq_pkg::ctl_t    word;
  logic              advance;

  assign word = ROM[step];

  always_comb begin
    in_ready  = 1'b0;
    advance   = 1'b1;
    step_next = step + STEP_W'(1);
    unique case (word.seq)
      sveq_pkg::SEQ_NEXT: ;
      sveq_pkg::SEQ_WAIT_IN: begin
        in_ready = 1'b1;
        advance  = in_valid;
      end
      sveq_pkg::SEQ_WAIT_OUT: begin
        advance   = out_free;
        step_next = '0;
      end
      default: ;
    endcase
  end

  assign ctl = advance ? word : sveq_pkg::ctl_t'('0);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (advance) begin
      step <= step_next;
    end
  end

endmodule

FILE: hw/rtl/sveq_datapath.sv
// ----------------------------------------------------------------------------
// State-variable EQ section datapath
// Shared 32x25 multiplier, accumulator, value registers, integrator states
// and the output register, all steered by the microcode control word.
// ----------------------------------------------------------------------------
module sveq_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sveq_pkg::ctl_t                       ctl,
  input  sveq_pkg::cfg_t                       cfg,
  input  logic signed [sveq_pkg::SAMPLE_W-1:0] sample_in,
  sveq_result_if.source                        results
);

  localparam int SW = sveq_pkg::STATE_W;
  localparam int AW = sveq_pkg::ACC_W;
  localparam int PW = sveq_pkg::PROD_W;
  localparam int BW = sveq_pkg::MUL_B_W;
  localparam int CF = sveq_pkg::COEF_FRAC;

  logic signed [SW-1:0] x;
  logic signed [SW-1:0] v2;
  logic signed [SW-1:0] v0;
  logic signed [SW-1:0] v1;
  logic signed [SW-1:0] y;
  logic signed [SW-1:0] s0;
  logic signed [SW-1:0] s1;
  logic signed [AW-1:0] acc;
  logic signed [PW-1:0] prod;
  logic                 clip;

  logic signed [sveq_pkg::COEF_W-1:0] mc;
  logic signed [SW-1:0]               vsel;
  logic signed [BW-1:0]               mv;
  logic signed [PW-1:0]               p;

  sveq_pkg::sat_state_t  sat_v2;
  sveq_pkg::sat_state_t  sat_acc;
  sveq_pkg::sat_state_t  sat_s0;
  sveq_pkg::sat_state_t  sat_s1;
  sveq_pkg::sat_sample_t sat_out;

  always_comb begin
    unique case (ctl.coef)
      sveq_pkg::C_NONE: mc = '0;
      sveq_pkg::C_A0:   mc = signed'(cfg.a0);
      sveq_pkg::C_A1:   mc = signed'(cfg.a1);
      sveq_pkg::C_A2:   mc = signed'(cfg.a2);
      sveq_pkg::C_M0:   mc = signed'(cfg.m0);
      sveq_pkg::C_M1:   mc = signed'(cfg.m1);
      sveq_pkg::C_M2:   mc = signed'(cfg.m2);
      sveq_pkg::C_GAIN: mc = signed'({1'b0, cfg.gain});
      default:          mc = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.val)
      sveq_pkg::V_S0: vsel = s0;
      sveq_pkg::V_V2: vsel = v2;
      sveq_pkg::V_X:  vsel = x;
      sveq_pkg::V_V0: vsel = v0;
      sveq_pkg::V_V1: vsel = v1;
      sveq_pkg::V_Y:  vsel = y;
      default:        vsel = '0;
    endcase
  end

  // The low half is unsigned and its product is floored on the way into
  // the product register, so each coefficient product is floored once.
  assign mv = (ctl.half == sveq_pkg::HALF_HI) ? BW'(signed'(vsel[SW-1:CF]))
                                             : BW'({1'b0, vsel[CF-1:0]});
  assign p  = PW'(mc) * PW'(mv);

  assign sat_v2  = sveq_pkg::sat_state(AW'(x) - AW'(s1));
  assign sat_acc = sveq_pkg::sat_state(acc);
  assign sat_s0  = sveq_pkg::sat_state((AW'(v0) <<< 1) - AW'(s0));
  assign sat_s1  = sveq_pkg::sat_state((AW'(v1) <<< 1) - AW'(s1));
  assign sat_out = sveq_pkg::sat_sample(acc);

  always_ff @(posedge clk) begin
    if (ctl.coef != sveq_pkg::C_NONE) begin
      prod <= (ctl.half == sveq_pkg::HALF_HI) ? p : (p >>> CF);
    end

    unique case (ctl.acc)
      sveq_pkg::ACC_HOLD:   ;
      sveq_pkg::ACC_CLR:    acc <= '0;
      sveq_pkg::ACC_ADD:    acc <= acc + AW'(prod);
      sveq_pkg::ACC_SET:    acc <= AW'(prod);
      sveq_pkg::ACC_S1_ADD: acc <= AW'(s1) + AW'(prod);
      default:              ;
    endcase

    unique case (ctl.wb)
      sveq_pkg::WB_NONE: ;
      sveq_pkg::WB_LOAD: begin
        x    <= SW'({sample_in, {sveq_pkg::STATE_FRAC{1'b0}}});
        clip <= 1'b0;
      end
      sveq_pkg::WB_V2: begin
        v2   <= sat_v2.val;
        clip <= clip | sat_v2.clip;
      end
      sveq_pkg::WB_V0: begin
        v0   <= sat_acc.val;
        clip <= clip | sat_acc.clip;
      end
      sveq_pkg::WB_V1: begin
        v1   <= sat_acc.val;
        clip <= clip | sat_acc.clip;
      end
      sveq_pkg::WB_STATE: begin
        clip <= clip | sat_s0.clip | sat_s1.clip;
      end
      sveq_pkg::WB_Y: begin
        y    <= sat_acc.val;
        clip <= clip | sat_acc.clip;
      end
      sveq_pkg::WB_OUT: begin
        results.sample_out <= sat_out.val;
        results.clipped    <= clip | sat_out.clip;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0            <= '0;
      s1            <= '0;
      results.valid <= 1'b0;
    end else begin
      if (ctl.wb == sveq_pkg::WB_STATE) begin
        s0 <= sat_s0.val;
        s1 <= sat_s1.val;
      end
      if (ctl.wb == sveq_pkg::WB_OUT) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

endmodule
